// ----- src/csd_pkg.sv -----
// Shared types and constants for the CORDIC sine/cosine unit.
// Holds the pipeline stage record, quadrant codes and the arctangent table.
// No dependencies.
package csd_pkg;

	localparam int FRACTION_BITS = 8;
	localparam int ANGLE_W = 17;
	localparam int XY_W = 11;
	localparam int ACC_W = 17;
	localparam int TRIG_W = 10;
	localparam int DAC_W = 8;
	localparam int TABLE_LEN = 15;

	localparam logic [ANGLE_W-1:0] DEG90  = ANGLE_W'(90 << FRACTION_BITS);
	localparam logic [ANGLE_W-1:0] DEG180 = ANGLE_W'(180 << FRACTION_BITS);
	localparam logic [ANGLE_W-1:0] DEG270 = ANGLE_W'(270 << FRACTION_BITS);
	localparam logic [ANGLE_W-1:0] DEG360 = ANGLE_W'(360 << FRACTION_BITS);

	localparam logic signed [XY_W-1:0] GAIN_START = XY_W'(155);
	localparam logic signed [XY_W+1-1:0] DAC_OFFSET = (XY_W+1)'(255);

	localparam logic [1:0] QUAD1 = 2'd0;
	localparam logic [1:0] QUAD2 = 2'd1;
	localparam logic [1:0] QUAD3 = 2'd2;
	localparam logic [1:0] QUAD4 = 2'd3;

	typedef struct packed {
		logic signed [XY_W-1:0]  x;
		logic signed [XY_W-1:0]  y;
		logic signed [ACC_W-1:0] acc;
		logic signed [ACC_W-1:0] target;
		logic [1:0]              quad;
		logic                    range_err;
	} csd_stage_t;

	// arctangent of 2^-idx in degrees * 256
	function automatic logic signed [ACC_W-1:0] atan_q8(input logic [3:0] idx);
		logic signed [ACC_W-1:0] r;
		case (idx)
			4'd0:    r = 17'sd11520;
			4'd1:    r = 17'sd6801;
			4'd2:    r = 17'sd3593;
			4'd3:    r = 17'sd1824;
			4'd4:    r = 17'sd916;
			4'd5:    r = 17'sd458;
			4'd6:    r = 17'sd229;
			4'd7:    r = 17'sd115;
			4'd8:    r = 17'sd57;
			4'd9:    r = 17'sd28;
			4'd10:   r = 17'sd14;
			4'd11:   r = 17'sd7;
			4'd12:   r = 17'sd4;
			4'd13:   r = 17'sd2;
			4'd14:   r = 17'sd1;
			default: r = 17'sd0;
		endcase
		return r;
	endfunction

endpackage

// ----- src/csd_fold.sv -----
// Input stage: range check and fold of the angle into the first quadrant.
// Depends on csd_pkg.
module csd_fold (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  logic                              in_valid,
	input  logic [csd_pkg::ANGLE_W-1:0]       angle,
	output logic                              out_valid,
	output csd_pkg::csd_stage_t               out_data
);

	logic                        valid_s1;
	csd_pkg::csd_stage_t         data_s1;
	csd_pkg::csd_stage_t         fold_d;
	logic [csd_pkg::ANGLE_W-1:0] tgt;

	always_comb begin
		fold_d = '0;
		tgt = '0;
		if (angle > csd_pkg::DEG360) begin
			fold_d.range_err = 1'b1;
			fold_d.quad = csd_pkg::QUAD1;
		end else if (angle <= csd_pkg::DEG90) begin
			tgt = angle;
			fold_d.quad = csd_pkg::QUAD1;
		end else if (angle <= csd_pkg::DEG180) begin
			tgt = csd_pkg::DEG180 - angle;
			fold_d.quad = csd_pkg::QUAD2;
		end else if (angle <= csd_pkg::DEG270) begin
			tgt = angle - csd_pkg::DEG180;
			fold_d.quad = csd_pkg::QUAD3;
		end else begin
			tgt = csd_pkg::DEG360 - angle;
			fold_d.quad = csd_pkg::QUAD4;
		end
		fold_d.target = $signed(tgt);
		fold_d.x = csd_pkg::GAIN_START;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			data_s1 <= fold_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// ----- src/csd_rotate.sv -----
// One CORDIC rotation step with its pipeline register.
// Depends on csd_pkg for the stage record and the arctangent table.
module csd_rotate #(
	parameter int STEP_IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic                in_valid,
	input  csd_pkg::csd_stage_t in_data,
	output logic                out_valid,
	output csd_pkg::csd_stage_t out_data
);

	localparam logic [3:0] TBL_IDX = 4'(STEP_IDX);

	logic                              valid_s2;
	csd_pkg::csd_stage_t               data_s2;
	csd_pkg::csd_stage_t               rot_d;
	logic signed [csd_pkg::XY_W-1:0]   x_sh;
	logic signed [csd_pkg::XY_W-1:0]   y_sh;
	logic signed [csd_pkg::ACC_W-1:0]  ang;

	always_comb begin
		x_sh = in_data.x >>> STEP_IDX;
		y_sh = in_data.y >>> STEP_IDX;
		ang = csd_pkg::atan_q8(TBL_IDX);
		rot_d = in_data;
		// equal angle: hold x, y and the accumulator
		if (in_data.acc < in_data.target) begin
			rot_d.x = in_data.x - y_sh;
			rot_d.y = in_data.y + x_sh;
			rot_d.acc = in_data.acc + ang;
		end else if (in_data.acc > in_data.target) begin
			rot_d.x = in_data.x + y_sh;
			rot_d.y = in_data.y - x_sh;
			rot_d.acc = in_data.acc - ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			data_s2 <= rot_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

// ----- src/cordic_sine_cosine_degrees_unit.sv -----
// CORDIC sine/cosine of an angle in degrees (8 fraction bits).
// Channels: angle_valid/angle_stall carry angle_deg_q8 in; result_valid/result_stall
// carry cos_out, sin_out, dac_code and range_error out. A beat moves when valid
// is high and stall is low.
// Pipeline: one fold stage, one stage per rotation step and one output stage;
// one beat can enter every cycle while angle_stall is low. Each rotation stage
// is one rotation adder pair plus a compare.
// When the receiver stalls, the output register holds its beat and stages fill
// up behind it; bubbles are squeezed out, and angle_stall rises only once every
// stage holds a beat. Nothing is dropped or repeated.
// Angles above 360 degrees give range_error = 1 with zero cos, sin and DAC code.
// Reset empties the pipeline at once; there is no state beyond the stages.
// Depends on csd_pkg, csd_fold and csd_rotate.
module cordic_sine_cosine_degrees_unit #(
	parameter int ROTATION_STEPS = 15
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                angle_valid,
	output logic                                angle_stall,
	input  logic [csd_pkg::ANGLE_W-1:0]         angle_deg_q8,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [csd_pkg::TRIG_W-1:0]   cos_out,
	output logic signed [csd_pkg::TRIG_W-1:0]   sin_out,
	output logic [csd_pkg::DAC_W-1:0]           dac_code,
	output logic                                range_error
);

	localparam int LAST = ROTATION_STEPS;

	logic                v   [0:LAST];
	csd_pkg::csd_stage_t st  [0:LAST];
	logic                rdy [0:LAST+1];

	logic                                  valid_s3;
	logic signed [csd_pkg::TRIG_W-1:0]     cos_s3;
	logic signed [csd_pkg::TRIG_W-1:0]     sin_s3;
	logic [csd_pkg::DAC_W-1:0]             dac_s3;
	logic                                  err_s3;

	logic signed [csd_pkg::XY_W-1:0]       xf;
	logic signed [csd_pkg::XY_W-1:0]       yf;
	logic signed [csd_pkg::XY_W+1-1:0]     dsum;
	logic signed [csd_pkg::XY_W+1-1:0]     dhalf;

	// a stage may load when it is empty or its successor is loading
	assign rdy[LAST+1] = !valid_s3 || !result_stall;
	generate
		for (genvar k = 0; k <= LAST; k++) begin : g_rdy
			assign rdy[k] = !v[k] || rdy[k+1];
		end
	endgenerate
	assign angle_stall = !rdy[0];

	csd_fold u_fold (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (rdy[0]),
		.in_valid  (angle_valid),
		.angle     (angle_deg_q8),
		.out_valid (v[0]),
		.out_data  (st[0])
	);

	generate
		for (genvar k = 0; k < ROTATION_STEPS; k++) begin : g_rot
			csd_rotate #(
				.STEP_IDX (k)
			) u_rot (
				.clk       (clk),
				.arst_n    (arst_n),
				.load      (rdy[k+1]),
				.in_valid  (v[k]),
				.in_data   (st[k]),
				.out_valid (v[k+1]),
				.out_data  (st[k+1])
			);
		end
	endgenerate

	// quadrant sign fix and DAC byte
	always_comb begin
		xf = st[LAST].x;
		yf = st[LAST].y;
		case (st[LAST].quad)
			csd_pkg::QUAD1: begin
			end
			csd_pkg::QUAD2: begin
				xf = -st[LAST].x;
			end
			csd_pkg::QUAD3: begin
				xf = -st[LAST].x;
				yf = -st[LAST].y;
			end
			csd_pkg::QUAD4: begin
				yf = -st[LAST].y;
			end
			default: begin
			end
		endcase
		dsum = (csd_pkg::XY_W+1)'(yf) + csd_pkg::DAC_OFFSET;
		// halve, truncating toward zero
		if (dsum < 0) begin
			dhalf = -((-dsum) >>> 1);
		end else begin
			dhalf = dsum >>> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy[LAST+1]) begin
			valid_s3 <= v[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[LAST+1] && v[LAST]) begin
			err_s3 <= st[LAST].range_err;
			if (st[LAST].range_err) begin
				cos_s3 <= '0;
				sin_s3 <= '0;
				dac_s3 <= '0;
			end else begin
				cos_s3 <= xf[csd_pkg::TRIG_W-1:0];
				sin_s3 <= yf[csd_pkg::TRIG_W-1:0];
				dac_s3 <= dhalf[csd_pkg::DAC_W-1:0];
			end
		end
	end

	assign result_valid = valid_s3;
	assign cos_out      = cos_s3;
	assign sin_out      = sin_s3;
	assign dac_code     = dac_s3;
	assign range_error  = err_s3;

	// input held off only with every stage full, output included; checked on the fold, last rotation and output stages
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		angle_stall |-> (result_valid && v[0] && v[LAST]))
		else $error("input stalled with a free stage");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && range_error) |-> (cos_out == '0 && sin_out == '0 && dac_code == '0))
		else $error("range error beat carries non-zero results");

	a_last_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v[LAST] && result_valid && result_stall) |=> v[LAST])
		else $error("last rotation stage lost a beat under stall");

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for cordic_sine_cosine_degrees_unit: drives angles, predicts
// cos, sin, DAC code and range flag, and checks every result beat in order.
// Depends on csd_pkg and the unit's RTL only.
module tb;

	localparam int ROTATION_STEPS = 15;
	localparam int RANDOM_ANGLES = 1830;
	localparam int HOLD_AT_RESULT = 400;
	localparam int HOLD_CYCLES = 120;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT = 300000;
	localparam int ARCTAN_Q8 [csd_pkg::TABLE_LEN] = '{11520, 6801, 3593, 1824, 916, 458,
		229, 115, 57, 28, 14, 7, 4, 2, 1};

	typedef struct {
		logic signed [csd_pkg::TRIG_W-1:0] cos_v;
		logic signed [csd_pkg::TRIG_W-1:0] sin_v;
		logic [csd_pkg::DAC_W-1:0]         dac;
		logic                              range_err;
	} trig_beat_t;

	class trig_scoreboard;
		trig_beat_t pending_trig[$];
		int errors;
		int results_seen;

		function trig_beat_t fold_and_rotate(logic [csd_pkg::ANGLE_W-1:0] a);
			int x, y, acc, target, nx, ny, s, q;
			logic [1:0] quad;
			trig_beat_t r;
			r.range_err = 1'b0;
			if (a > csd_pkg::DEG360) begin
				r.cos_v = '0;
				r.sin_v = '0;
				r.dac = '0;
				r.range_err = 1'b1;
				return r;
			end
			if (a <= csd_pkg::DEG90) begin
				target = int'(a);
				quad = csd_pkg::QUAD1;
			end else if (a <= csd_pkg::DEG180) begin
				target = int'(csd_pkg::DEG180) - int'(a);
				quad = csd_pkg::QUAD2;
			end else if (a <= csd_pkg::DEG270) begin
				target = int'(a) - int'(csd_pkg::DEG180);
				quad = csd_pkg::QUAD3;
			end else begin
				target = int'(csd_pkg::DEG360) - int'(a);
				quad = csd_pkg::QUAD4;
			end
			x = int'(csd_pkg::GAIN_START);
			y = 0;
			acc = 0;
			for (int i = 0; i < ROTATION_STEPS; i++) begin
				nx = x;
				ny = y;
				// hold x, y and the angle when the running angle has hit the target
				if (acc < target) begin
					nx = x - (y >>> i);
					ny = y + (x >>> i);
					acc += ARCTAN_Q8[i];
				end else if (acc > target) begin
					nx = x + (y >>> i);
					ny = y - (x >>> i);
					acc -= ARCTAN_Q8[i];
				end
				x = nx;
				y = ny;
			end
			case (quad)
				csd_pkg::QUAD2: x = -x;
				csd_pkg::QUAD3: begin
					x = -x;
					y = -y;
				end
				csd_pkg::QUAD4: y = -y;
				default: ;
			endcase
			s = y + 255;
			q = s / 2;
			r.cos_v = x[csd_pkg::TRIG_W-1:0];
			r.sin_v = y[csd_pkg::TRIG_W-1:0];
			r.dac = q[csd_pkg::DAC_W-1:0];
			return r;
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		function void note_angle(logic [csd_pkg::ANGLE_W-1:0] a);
			pending_trig.push_back(fold_and_rotate(a));
		endfunction

		task check_result(logic signed [csd_pkg::TRIG_W-1:0] c,
				logic signed [csd_pkg::TRIG_W-1:0] s,
				logic [csd_pkg::DAC_W-1:0] d, logic re);
			trig_beat_t e;
			results_seen++;
			if (pending_trig.size() == 0) begin
				report($sformatf("result beat %0d with no angle outstanding", results_seen));
				return;
			end
			e = pending_trig.pop_front();
			if (c !== e.cos_v)
				report($sformatf("beat %0d cos_out %0d, want %0d", results_seen, c, e.cos_v));
			if (s !== e.sin_v)
				report($sformatf("beat %0d sin_out %0d, want %0d", results_seen, s, e.sin_v));
			if (d !== e.dac)
				report($sformatf("beat %0d dac_code %0d, want %0d", results_seen, d, e.dac));
			if (re !== e.range_err)
				report($sformatf("beat %0d range_error %0b, want %0b", results_seen, re,
					e.range_err));
		endtask

		function int outstanding();
			return pending_trig.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic angle_valid;
	logic angle_stall;
	logic [csd_pkg::ANGLE_W-1:0] angle_deg_q8;
	logic result_valid;
	logic result_stall;
	logic signed [csd_pkg::TRIG_W-1:0] cos_out;
	logic signed [csd_pkg::TRIG_W-1:0] sin_out;
	logic [csd_pkg::DAC_W-1:0] dac_code;
	logic range_error;

	trig_scoreboard sb;
	int cycles = 0;
	bit sender_gapless;

	cordic_sine_cosine_degrees_unit #(
		.ROTATION_STEPS(ROTATION_STEPS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.angle_valid(angle_valid),
		.angle_stall(angle_stall),
		.angle_deg_q8(angle_deg_q8),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.cos_out(cos_out),
		.sin_out(sin_out),
		.dac_code(dac_code),
		.range_error(range_error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** cordic_sine_cosine_degrees_unit: FAILED **");
			$finish;
		end
	end

	// offer one angle beat after a drawn gap and hold it until accepted
	task send_angle(logic [csd_pkg::ANGLE_W-1:0] a);
		int gap;
		gap = sender_gapless ? 0 : $urandom_range(0, 3);
		for (int k = 0; k < gap; k++) begin
			@(negedge clk);
			angle_valid <= 1'b0;
		end
		@(negedge clk);
		angle_valid <= 1'b1;
		angle_deg_q8 <= a;
		do @(posedge clk); while (angle_stall);
		sb.note_angle(a);
	endtask

	task wait_drained();
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	task drain_results();
		int gap;
		bit gapless;
		bit held;
		held = 1'b0;
		gapless = 1'b0;
		forever begin
			if (sb.results_seen % 64 == 0)
				gapless = ($urandom_range(0, 3) == 0);
			gap = gapless ? 0 : $urandom_range(0, 3);
			// long hold-off so the pipeline fills and back-pressures the input
			if (!held && sb.results_seen == HOLD_AT_RESULT) begin
				held = 1'b1;
				gap = HOLD_CYCLES;
			end
			for (int k = 0; k < gap; k++) begin
				@(negedge clk);
				result_stall <= 1'b1;
			end
			@(negedge clk);
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
			sb.check_result(cos_out, sin_out, dac_code, range_error);
		end
	endtask

	function logic [csd_pkg::ANGLE_W-1:0] draw_angle();
		int pick;
		int edges [4];
		pick = $urandom_range(0, 99);
		edges = '{int'(csd_pkg::DEG90), int'(csd_pkg::DEG180), int'(csd_pkg::DEG270),
			int'(csd_pkg::DEG360)};
		if (pick < 8)
			return csd_pkg::ANGLE_W'($urandom_range(int'(csd_pkg::DEG360) + 1,
				(1 << csd_pkg::ANGLE_W) - 1));
		if (pick < 14)
			return csd_pkg::ANGLE_W'(edges[$urandom_range(0, 3)] + $urandom_range(0, 6) - 3);
		return csd_pkg::ANGLE_W'($urandom_range(0, int'(csd_pkg::DEG360)));
	endfunction

	initial begin
		logic [csd_pkg::ANGLE_W-1:0] directed [$];
		sb = new();
		sender_gapless = 1'b0;
		arst_n = 1'b0;
		angle_valid = 1'b0;
		angle_deg_q8 = '0;
		result_stall = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		fork
			drain_results();
		join_none
		// quadrant edges, exact table hits that skip later steps, out-of-range
		directed = '{0, 1, 11520, 4719, 18321, 7680, 23039, 23040, 23041, 34560, 46079,
			46080, 46081, 57600, 65536, 69119, 69120, 69121, 80640, 92159, 92160, 92161,
			131071};
		foreach (directed[n])
			send_angle(directed[n]);
		@(negedge clk);
		angle_valid <= 1'b0;
		wait_drained();
		for (int n = 0; n < RANDOM_ANGLES; n++) begin
			if (n % 64 == 0)
				sender_gapless = ($urandom_range(0, 3) == 0);
			if (n == RANDOM_ANGLES / 2) begin
				@(negedge clk);
				angle_valid <= 1'b0;
				wait_drained();
			end
			send_angle(draw_angle());
		end
		@(negedge clk);
		angle_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("** cordic_sine_cosine_degrees_unit: PASSED **");
		else
			$display("** cordic_sine_cosine_degrees_unit: FAILED **");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/csd_pkg.sv
src/csd_fold.sv
src/csd_rotate.sv
src/cordic_sine_cosine_degrees_unit.sv
bench/tb.sv
